@@ rtl/core/rar_pkg.sv @@
// Package: widths, operation codes and controller/datapath handshake structs.
package rar_pkg;

   localparam int OPERAND_BITS = 16;
   localparam int MAG_W        = OPERAND_BITS;
   localparam int PROD_W       = 2 * OPERAND_BITS;
   localparam int SUM_W        = PROD_W + 1;
   localparam int NUM_OUT_W    = 33;
   localparam int DEN_OUT_W    = 31;
   localparam int EXT_W        = (SUM_W + 1 > NUM_OUT_W) ? SUM_W + 1 : NUM_OUT_W;
   localparam int SHIFT_W      = $clog2(SUM_W);
   localparam int CNT_W        = $clog2(SUM_W);

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      logic load_in;
      logic mul;
      logic sum;
      logic gcd_step;
      logic div_load;
      logic div_step;
      logic out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic skip;
      logic gcd_done;
      logic div_last;
   } ctl_stat_type;

endpackage

@@ rtl/core/rar_ifs.sv @@
// Interfaces: request and response channels.
interface rar_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [1:0]                              cmd;
   logic signed [rar_pkg::OPERAND_BITS-1:0] a_num;
   logic signed [rar_pkg::OPERAND_BITS-1:0] a_den;
   logic signed [rar_pkg::OPERAND_BITS-1:0] b_num;
   logic signed [rar_pkg::OPERAND_BITS-1:0] b_den;
   modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
   modport sink   (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [rar_pkg::NUM_OUT_W-1:0] res_num;
   logic [rar_pkg::DEN_OUT_W-1:0]        res_den;
   logic                                 error;
   modport source (output valid, res_num, res_den, error, input ready);
   modport sink   (input valid, res_num, res_den, error, output ready);
endinterface

@@ rtl/core/rar_ctrl.sv @@
// Controller: sequences multiply, sum, binary GCD, division and output load.
module rar_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rar_pkg::ctl_stat_type stat,
   output rar_pkg::ctl_cmd_type  cmd
);
   import rar_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_MUL  = 6'b000010,
      S_SUM  = 6'b000100,
      S_GCD  = 6'b001000,
      S_DIV  = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = stat.skip ? S_DONE : S_GCD;
         end
         S_GCD: begin
            if (stat.gcd_done) begin
               cmd.div_load = 1'b1;
               state_in     = S_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
      else out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_to_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> state_ff == S_MUL)
      else $error("accepted request did not start multiply");
   a_skip_to_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM && stat.skip) |=> state_ff == S_DONE)
      else $error("special case did not skip reduction");
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> out_valid_ff)
      else $error("output load lost");
`endif

endmodule

@@ rtl/core/rar_dpath.sv @@
// Datapath: operand decode, products, signed sum, binary GCD and exact division.
module rar_dpath (
   input  logic                                    clock,
   input  rar_pkg::ctl_cmd_type                    cmd,
   output rar_pkg::ctl_stat_type                   stat,
   input  logic [1:0]                              in_cmd,
   input  logic signed [rar_pkg::OPERAND_BITS-1:0] in_a_num,
   input  logic signed [rar_pkg::OPERAND_BITS-1:0] in_a_den,
   input  logic signed [rar_pkg::OPERAND_BITS-1:0] in_b_num,
   input  logic signed [rar_pkg::OPERAND_BITS-1:0] in_b_den,
   output logic signed [rar_pkg::NUM_OUT_W-1:0]    out_num,
   output logic [rar_pkg::DEN_OUT_W-1:0]           out_den,
   output logic                                    out_err
);
   import rar_pkg::*;

   op_type              op_ff;
   logic [MAG_W-1:0]    an_ff, ad_ff, bn_ff, bd_ff;
   logic                an_neg_ff, ad_neg_ff, bn_neg_ff, bd_neg_ff;
   logic [PROD_W-1:0]   px_ff, py_ff, pd_ff;
   logic                x_neg_ff, y_neg_ff, d_neg_ff, in_zero_ff;
   logic [SUM_W-1:0]    u_ff, v_ff;
   logic [SHIFT_W-1:0]  k_ff;
   logic                neg_ff, err_ff, zero_ff;
   logic [SUM_W-1:0]    dvs_ff, qn_ff, qd_ff, rn_ff, rd_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic signed [NUM_OUT_W-1:0] out_num_ff;
   logic [DEN_OUT_W-1:0]        out_den_ff;
   logic                        out_err_ff;

   logic [SUM_W-1:0]    sx, sy, s_mag, s_den;
   logic                s_neg, s_err;
   logic [SUM_W:0]      rn_sh, rd_sh;
   logic                n_ge, d_ge;
   logic [EXT_W-1:0]    n_ext, d_ext;

   function automatic logic [MAG_W-1:0] mag_of(input logic [MAG_W-1:0] v);
      return v[MAG_W-1] ? (~v + 1'b1) : v;
   endfunction

   // signed sum of the two cross products for add/subtract; multiply and divide pass the single product through
   always_comb begin
      sx = {1'b0, px_ff};
      sy = (op_ff == OP_ADD || op_ff == OP_SUB) ? {1'b0, py_ff} : '0;
      if (x_neg_ff == y_neg_ff) begin
         s_mag = sx + sy;
         s_neg = x_neg_ff;
      end else if (sx >= sy) begin
         s_mag = sx - sy;
         s_neg = x_neg_ff;
      end else begin
         s_mag = sy - sx;
         s_neg = y_neg_ff;
      end
      s_den = {1'b0, pd_ff};
      s_err = in_zero_ff || (pd_ff == '0);
   end

   assign stat.skip     = s_err || (s_mag == '0);
   assign stat.gcd_done = (u_ff == v_ff);
   assign stat.div_last = (cnt_ff == CNT_W'(SUM_W - 1));

   assign rn_sh = {rn_ff, qn_ff[SUM_W-1]};
   assign rd_sh = {rd_ff, qd_ff[SUM_W-1]};
   assign n_ge  = rn_sh >= {1'b0, dvs_ff};
   assign d_ge  = rd_sh >= {1'b0, dvs_ff};

   assign n_ext = neg_ff ? (EXT_W'(0) - EXT_W'(qn_ff)) : EXT_W'(qn_ff);
   assign d_ext = EXT_W'(qd_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         op_ff     <= op_type'(in_cmd);
         an_ff     <= mag_of(in_a_num);
         ad_ff     <= mag_of(in_a_den);
         bn_ff     <= mag_of(in_b_num);
         bd_ff     <= mag_of(in_b_den);
         an_neg_ff <= in_a_num[MAG_W-1];
         ad_neg_ff <= in_a_den[MAG_W-1];
         bn_neg_ff <= in_b_num[MAG_W-1];
         bd_neg_ff <= in_b_den[MAG_W-1];
      end
      if (cmd.mul) begin
         px_ff      <= PROD_W'(an_ff) * PROD_W'((op_ff == OP_MUL) ? bn_ff : bd_ff);
         py_ff      <= PROD_W'(bn_ff) * PROD_W'(ad_ff);
         pd_ff      <= PROD_W'(ad_ff) * PROD_W'((op_ff == OP_DIV) ? bn_ff : bd_ff);
         x_neg_ff   <= an_neg_ff ^ ((op_ff == OP_MUL) ? bn_neg_ff : bd_neg_ff);
         y_neg_ff   <= bn_neg_ff ^ ad_neg_ff ^ (op_ff == OP_SUB);
         d_neg_ff   <= ad_neg_ff ^ ((op_ff == OP_DIV) ? bn_neg_ff : bd_neg_ff);
         in_zero_ff <= (ad_ff == '0) || (bd_ff == '0);
      end
      if (cmd.sum) begin
         u_ff    <= s_mag;
         v_ff    <= s_den;
         k_ff    <= '0;
         neg_ff  <= s_neg ^ d_neg_ff;
         err_ff  <= s_err;
         zero_ff <= (s_mag == '0);
         qn_ff   <= s_mag;
         qd_ff   <= s_den;
      end
      // binary GCD step: strip shared twos, halve an even operand, then subtract
      if (cmd.gcd_step) begin
         if (!u_ff[0] && !v_ff[0]) begin
            u_ff <= u_ff >> 1;
            v_ff <= v_ff >> 1;
            k_ff <= k_ff + 1'b1;
         end else if (!u_ff[0]) begin
            u_ff <= u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_ff <= v_ff >> 1;
         end else if (u_ff > v_ff) begin
            u_ff <= u_ff - v_ff;
         end else begin
            v_ff <= v_ff - u_ff;
         end
      end
      if (cmd.div_load) begin
         dvs_ff <= u_ff << k_ff;
         rn_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end
      // restoring division, one quotient bit per lane each cycle
      if (cmd.div_step) begin
         rn_ff  <= n_ge ? SUM_W'(rn_sh - {1'b0, dvs_ff}) : rn_sh[SUM_W-1:0];
         rd_ff  <= d_ge ? SUM_W'(rd_sh - {1'b0, dvs_ff}) : rd_sh[SUM_W-1:0];
         qn_ff  <= {qn_ff[SUM_W-2:0], n_ge};
         qd_ff  <= {qd_ff[SUM_W-2:0], d_ge};
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.out_load) begin
         if (err_ff) begin
            out_num_ff <= '0;
            out_den_ff <= '0;
            out_err_ff <= 1'b1;
         end else if (zero_ff) begin
            out_num_ff <= '0;
            out_den_ff <= DEN_OUT_W'(1);
            out_err_ff <= 1'b0;
         end else begin
            out_num_ff <= n_ext[NUM_OUT_W-1:0];
            out_den_ff <= d_ext[DEN_OUT_W-1:0];
            out_err_ff <= 1'b0;
         end
      end
   end

   assign out_num = out_num_ff;
   assign out_den = out_den_ff;
   assign out_err = out_err_ff;

endmodule

@@ rtl/core/rational_arith_reduce.sv @@
// Top level: rational add/subtract/multiply/divide with GCD reduction.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------
//  req_ch   | in        | cmd, a_num, a_den, b_num, b_den
//  rsp_ch   | out       | res_num, res_den, error
//
// One request at a time: the operands are registered, then the products and the
// signed sum are formed, then the binary GCD loop runs (one shift or subtract per
// cycle, data dependent) and the divisor is loaded, then restoring division divides
// numerator and denominator by the GCD side by side, then the output register is
// loaded. Zero-numerator and zero-denominator cases skip the loops. The output
// register lets the next request enter while a response waits on rsp_ch.ready.
// Reset is synchronous; no state survives between items.
module rational_arith_reduce (
   input  logic      clock,
   input  logic      reset,
   rar_req_if.sink   req_ch,
   rar_rsp_if.source rsp_ch
);
   import rar_pkg::*;

   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   // sequence the steps for each request
   rar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // hold operands, run the arithmetic, hold the response payload
   rar_dpath u_dpath (
      .clock    (clock),
      .cmd      (cmd),
      .stat     (stat),
      .in_cmd   (req_ch.cmd),
      .in_a_num (req_ch.a_num),
      .in_a_den (req_ch.a_den),
      .in_b_num (req_ch.b_num),
      .in_b_den (req_ch.b_den),
      .out_num  (rsp_ch.res_num),
      .out_den  (rsp_ch.res_den),
      .out_err  (rsp_ch.error)
   );

endmodule
